>>> rtl/sec_pkg.sv
`timescale 1ns / 1ps

package sec_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MONO          = 3'd3;

    // mode codes, the unused code runs free
    localparam logic [1:0] MODE_FREE_RUN = 2'd0;
    localparam logic [1:0] MODE_RISING   = 2'd1;
    localparam logic [1:0] MODE_FALLING  = 2'd2;

    localparam int SAMPLE_W = 16;
    localparam int WLEN_W   = 13;
    localparam int WIDX_W   = 12;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 13'd4096;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [SAMPLE_W-1:0] threshold;
        logic [WLEN_W-1:0]          window_length;
        logic                       mono;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic [WIDX_W-1:0]          window_index;
        logic                       first_of_window;
        logic                       last_of_window;
    } t_out_item;

endpackage

>>> rtl/sec_in_if.sv
`timescale 1ns / 1ps

interface sec_in_if
    import sec_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sec_out_if.sv
`timescale 1ns / 1ps

interface sec_out_if
    import sec_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sec_trigger.sv
`timescale 1ns / 1ps

module sec_trigger
    import sec_pkg::*;
#(
    parameter int MAX_WINDOW_LEN = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_clear,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_emit,
    output t_out_item o_result
);

    localparam int PW = $clog2(MAX_WINDOW_LEN);
    localparam int LW = $clog2(MAX_WINDOW_LEN + 1);
    localparam int CW = (LW > WLEN_W) ? LW : WLEN_W;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_WINDOW_LEN);

    logic signed [SAMPLE_W-1:0] r_prev_level;
    logic                       r_prev_valid;
    logic                       r_capturing;
    logic [PW-1:0]              r_pos;

    logic signed [SAMPLE_W-1:0] n_prev_level;
    logic                       n_prev_valid;
    logic                       n_capturing;
    logic [PW-1:0]              n_pos;

    logic          trig_mode;
    logic          hit;
    logic [CW-1:0] wl_ext;
    logic [CW-1:0] len;
    logic [PW-1:0] pos_cur;
    logic [CW-1:0] pos_inc;
    logic          last;

    // effective window length, zero taken as one, clipped to the maximum
    always_comb begin
        wl_ext = CW'(i_cfg.window_length);
        if (wl_ext == '0) begin
            len = CW'(1);
        end else if (wl_ext > MAX_LEN) begin
            len = MAX_LEN;
        end else begin
            len = wl_ext;
        end
    end

    always_comb begin
        trig_mode = 1'b0;
        hit       = 1'b0;
        case (i_cfg.mode)
            MODE_RISING: begin
                trig_mode = 1'b1;
                hit = (r_prev_level < i_cfg.threshold)
                      && (i_item.left_sample >= i_cfg.threshold);
            end
            MODE_FALLING: begin
                trig_mode = 1'b1;
                hit = (r_prev_level > i_cfg.threshold)
                      && (i_item.left_sample <= i_cfg.threshold);
            end
            default: begin
                trig_mode = 1'b0;
                hit       = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_emit  = trig_mode ? (r_capturing || (r_prev_valid && hit)) : 1'b1;
        // a fresh trigger starts at position zero
        pos_cur = (trig_mode && !r_capturing) ? '0 : r_pos;
        pos_inc = CW'(pos_cur) + CW'(1);
        last    = (pos_inc >= len);

        o_result.out_left        = i_item.left_sample;
        o_result.out_right       = i_cfg.mono ? i_item.left_sample : i_item.right_sample;
        o_result.window_index    = WIDX_W'(pos_cur);
        o_result.first_of_window = (pos_cur == '0);
        o_result.last_of_window  = last;
    end

    always_comb begin
        n_prev_level = r_prev_level;
        n_prev_valid = r_prev_valid;
        n_capturing  = r_capturing;
        n_pos        = r_pos;
        if (i_step) begin
            n_prev_level = i_item.left_sample;
            n_prev_valid = 1'b1;
            if (o_emit) begin
                if (last) begin
                    n_capturing = 1'b0;
                    n_pos       = '0;
                end else begin
                    n_capturing = 1'b1;
                    n_pos       = PW'(pos_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_prev_level <= '0;
            r_prev_valid <= 1'b0;
            r_capturing  <= 1'b0;
            r_pos        <= '0;
        end else begin
            r_prev_level <= n_prev_level;
            r_prev_valid <= n_prev_valid;
            r_capturing  <= n_capturing;
            r_pos        <= n_pos;
        end
    end

endmodule

>>> rtl/scope_edge_trigger_capture.sv
// Edge-triggered window capture for a stereo sample stream. Each input item is a
// left/right pair of signed Q1.15 samples; in free-run mode every item comes out,
// cut into windows of window_length samples, and in rising or falling mode the
// left channel is compared with the trigger threshold and the crossing sample opens
// a window, the search for the next crossing starting again straight after the
// window closes (the sample just after a window may trigger at once). Dropped
// items produce no result. Each result carries its position in the window and
// first and last marks; a window of one sample has both marks set. Any write on
// the configuration port, even to an unused index, resets the trigger state, so
// write only while the block is idle. Throughput is one item per clock while results
// are taken; an accepted item passes through an input register and then a result
// register, with the compare and window counter between them. The input side keeps
// accepting while a result waits to be taken, and stalls only once both registers
// are full.
`timescale 1ns / 1ps

module scope_edge_trigger_capture
    import sec_pkg::*;
#(
    parameter int MAX_WINDOW_LEN = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample pairs in, captured items out
    sec_in_if.sink                i_in,
    sec_out_if.source             o_out
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      advance;
    logic      emit;
    t_out_item result;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= MODE_FREE_RUN;
            r_cfg.threshold     <= '0;
            r_cfg.window_length <= WLEN_RESET;
            r_cfg.mono          <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:          r_cfg.mode          <= i_cfg_data[1:0];
                REG_THRESHOLD:     r_cfg.threshold     <= i_cfg_data;
                REG_WINDOW_LENGTH: r_cfg.window_length <= i_cfg_data[WLEN_W-1:0];
                REG_MONO:          r_cfg.mono          <= i_cfg_data[0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // flow control: the registered item moves on whenever the result
    // register is empty or being emptied this cycle
    // ---------------------------------------------------------------------
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    // trigger search and window counter, stepped once per item
    sec_trigger #(
        .MAX_WINDOW_LEN (MAX_WINDOW_LEN)
    ) u_trigger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_clear  (i_cfg_we),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_emit   (emit),
        .o_result (result)
    );

    // result register, a dropped item leaves it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_item <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule

>>> rtl/sec_checker.sv
`timescale 1ns / 1ps

module sec_checker
    import sec_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped or changed while stalled");

    // with no result waiting the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // a new result follows an accepted item
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching item");

    // the opening sample of a window sits at position zero
    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.first_of_window |-> i_out_data.window_index == '0)
        else $error("first of window at non-zero position");

endmodule

bind scope_edge_trigger_capture sec_checker u_sec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
